### rtl/delta_huffman_encoder_assert.svh
// Assertion macros for the delta Huffman encoder.
`ifndef DELTA_HUFFMAN_ENCODER_ASSERT_SVH
`define DELTA_HUFFMAN_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define DHE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("delta_huffman_encoder: check failed");

// Checked on every clock edge, reset included.
`define DHE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("delta_huffman_encoder: check failed");

`else

`define DHE_ASSERT(lbl, prop)
`define DHE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### rtl/dhe_pkg.sv
// Shared types and constants of the delta Huffman encoder.
package dhe_pkg;

    // Request commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam int BYTE_BITS  = 8;
    localparam int WORD_BITS  = 32;
    localparam int LEN_W      = 6;
    // Packer: up to seven pending bits plus a full code word
    localparam int ACC_W      = WORD_BITS + BYTE_BITS;

    // One code table entry
    typedef struct packed {
        logic [LEN_W-1:0]     len;
        logic [WORD_BITS-1:0] word;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE,
        S_EMIT
    } t_state;

endpackage

### rtl/dhe_code_table.sv
// Code table: single-port write, one registered read port.
module dhe_code_table #(
    parameter int SYMBOLS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(SYMBOLS)-1:0] i_wr_addr,
    input  dhe_pkg::t_entry            i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(SYMBOLS)-1:0] i_rd_addr,
    output dhe_pkg::t_entry            o_rd_data
);
    import dhe_pkg::*;

    t_entry r_mem [SYMBOLS];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/delta_huffman_encoder.sv
// Delta Huffman encoder top level: request decode, bit packer and byte output.
//
// Pixels are delta coded against the previous pixel and each delta selects a prefix
// code from an on-chip table, which is packed MSB first into bytes. One request is
// handled at a time. A load writes its table entry when accepted. An encode reads
// the table, then merges the code into the packer, then emits each byte it completes,
// zero to four; the output register sends one byte per cycle unless the output side
// stalls. A flush emits a pending partial byte, padded with zeros, if there is one.
// The table holds no valid bits: encoding a delta whose entry was never loaded gives
// undefined output. The last flag marks the final byte caused by one request.
module delta_huffman_encoder #(
    parameter int SYMBOLS       = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_pixel,
    input  logic [31:0] i_code_bits,
    input  logic [5:0]  i_code_length,
    // Byte channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import dhe_pkg::*;

    `include "delta_huffman_encoder_assert.svh"

    localparam int IDX_W = $clog2(SYMBOLS);
    localparam int CAP   = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;

    t_state           r_state, n_state;
    logic [7:0]       r_prev, n_prev;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_hit, n_hit;
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_obyte, n_obyte;
    logic             r_olast, n_olast;

    logic             in_accept;
    logic             out_free;
    logic [7:0]       delta;
    logic             load_hit;
    logic             delta_hit;
    logic [LEN_W-1:0] len_capped;
    logic             tbl_wr_en;
    logic             tbl_rd_en;
    t_entry           tbl_wr_data;
    t_entry           tbl_rd_data;
    logic [LEN_W-1:0] code_len;
    logic [6:0]       align_sh;
    logic [WORD_BITS-1:0] code_left;
    logic [ACC_W-1:0] code_acc;
    logic [LEN_W-1:0] merge_cnt;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_ovalid || !i_out_stall;
    assign delta     = i_pixel - r_prev;
    assign load_hit  = {1'b0, i_pixel} < 9'(SYMBOLS);
    assign delta_hit = {1'b0, delta} < 9'(SYMBOLS);
    assign len_capped = (i_code_length > LEN_W'(CAP)) ? LEN_W'(CAP) : i_code_length;

    // Table access
    assign tbl_wr_en   = in_accept && (i_command == CMD_LOAD) && load_hit;
    assign tbl_rd_en   = in_accept && (i_command == CMD_ENCODE);
    assign tbl_wr_data = '{len: len_capped, word: i_code_bits};

    dhe_code_table #(
        .SYMBOLS (SYMBOLS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (i_pixel[IDX_W-1:0]),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (delta[IDX_W-1:0]),
        .o_rd_data (tbl_rd_data)
    );

    // Left-align the code word and place it just below the pending bits
    assign code_len  = r_hit ? tbl_rd_data.len : '0;
    assign align_sh  = 7'(WORD_BITS) - {1'b0, code_len};
    assign code_left = tbl_rd_data.word << align_sh;
    assign code_acc  = {code_left, {BYTE_BITS{1'b0}}} >> r_cnt[2:0];
    assign merge_cnt = r_cnt + code_len;

    // Next state and datapath
    always_comb begin
        n_state  = r_state;
        n_prev   = r_prev;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_ovalid = r_ovalid && i_out_stall;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        o_in_stall = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_command)
                        CMD_ENCODE: begin
                            n_prev  = i_pixel;
                            n_hit   = delta_hit;
                            n_state = S_MERGE;
                        end
                        CMD_FLUSH: begin
                            // Pad bits below the pending ones are already zero
                            n_prev = '0;
                            if (r_cnt != '0) begin
                                n_cnt   = LEN_W'(BYTE_BITS);
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MERGE: begin
                n_acc   = r_acc | code_acc;
                n_cnt   = merge_cnt;
                n_state = (merge_cnt >= LEN_W'(BYTE_BITS)) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (r_cnt < LEN_W'(BYTE_BITS)) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_acc[ACC_W-1 -: BYTE_BITS];
                    n_olast  = r_cnt < LEN_W'(2 * BYTE_BITS);
                    n_acc    = r_acc << BYTE_BITS;
                    n_cnt    = r_cnt - LEN_W'(BYTE_BITS);
                    if (r_cnt < LEN_W'(2 * BYTE_BITS)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and packer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prev   <= n_prev;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_hit    <= n_hit;
            r_ovalid <= n_ovalid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last      = r_olast;

    // Between requests fewer than eight bits wait, with zeros below them
    `DHE_ASSERT(a_idle_partial, (r_state == S_IDLE) |-> (r_cnt < LEN_W'(BYTE_BITS)))
    `DHE_ASSERT(a_idle_clean, (r_state == S_IDLE) |-> ((r_acc << r_cnt) == '0))
    // A merge follows directly on an accepted encode
    `DHE_ASSERT(a_merge_follows, (r_state == S_MERGE) |->
        $past(in_accept && (i_command == CMD_ENCODE)))
    // A new byte is only loaded from the emit state
    `DHE_ASSERT(a_byte_from_emit, (r_ovalid && !$past(r_ovalid)) |->
        $past(r_state == S_EMIT))

endmodule

### tb/sv/delta_huffman_encoder_tb.sv
// Self-checking testbench for the delta Huffman encoder: directed and random requests.
module delta_huffman_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dhe_pkg::*;

    localparam int PERIOD        = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SYMBOLS       = 256;
    localparam int MAX_CODE_BITS = 32;
    localparam int CODE_CAP      = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CALM_TAIL     = 60;
    localparam int STUCK_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    // Request code nobody decodes; the block must drop it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  pix;
        logic [31:0] bits;
        logic [5:0]  len;
    } t_request;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command = CMD_LOAD;
    logic [7:0]  i_pixel = 8'd0;
    logic [31:0] i_code_bits = 32'd0;
    logic [5:0]  i_code_length = 6'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;

    // Requests waiting to be driven, bytes the packer should produce
    t_request  pending_reqs[$];
    t_out_byte expected_bytes[$];

    // Generator's view of the block, used to keep every encode on a loaded entry
    logic [7:0] gen_prev;
    logic       gen_loaded [SYMBOLS];
    int         loaded_syms[$];

    // Predictor state
    logic [31:0] code_word_tbl [SYMBOLS];
    logic [5:0]  code_len_tbl  [SYMBOLS];
    logic [7:0]  pred_prev;
    logic [7:0]  pack_buf;
    int          pack_cnt;

    int  mismatches = 0;
    int  reqs_taken = 0;
    int  bytes_seen = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  stuck_cycles = 0;
    logic calm = 1'b0;

    always #(PERIOD/2) i_clk = ~i_clk;

    delta_huffman_encoder #(
        .SYMBOLS       (SYMBOLS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_pixel       (i_pixel),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at byte %0d: got %0h, expected %0h",
                 what, bytes_seen, got, want);
        mismatches++;
    endtask

    // Queue one request and keep the generator's view in step
    task automatic queue_request(input logic [1:0] cmd, input logic [7:0] pix,
                                 input logic [31:0] bits, input logic [5:0] len);
        t_request r;
        r = '{cmd: cmd, pix: pix, bits: bits, len: len};
        pending_reqs.push_back(r);
        case (cmd)
            CMD_LOAD: begin
                if (!gen_loaded[pix]) begin
                    gen_loaded[pix] = 1'b1;
                    loaded_syms.push_back(int'(pix));
                end
            end
            CMD_ENCODE: gen_prev = pix;
            CMD_FLUSH:  gen_prev = 8'd0;
            default: ;
        endcase
    endtask

    // Load a random entry; small deltas are favoured as in a smooth image
    task automatic queue_random_load();
        logic [7:0]  sym;
        logic [31:0] bits;
        logic [5:0]  len;
        int          pick;
        if ($urandom_range(0, 1) == 0)
            sym = 8'($urandom_range(0, 6) - 3);
        else
            sym = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 15);
        case (pick)
            0:       len = 6'd0;
            1:       len = 6'd32;
            2:       len = 6'($urandom_range(33, 63));
            3, 4, 5: len = 6'($urandom_range(9, 31));
            default: len = 6'($urandom_range(1, 8));
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0)
            bits = 32'd0;
        else if (pick == 1)
            bits = 32'hFFFF_FFFF;
        else
            bits = $urandom();
        queue_request(CMD_LOAD, sym, bits, len);
    endtask

    // Work out the bytes that one accepted request should produce
    task automatic predict_bytes(input t_request r);
        logic [7:0]  made [4];
        logic [7:0]  delta;
        logic [31:0] w;
        int          l;
        int          n;
        n = 0;
        case (r.cmd)
            CMD_LOAD: begin
                code_word_tbl[r.pix] = r.bits;
                code_len_tbl[r.pix]  = (int'(r.len) > CODE_CAP) ? 6'(CODE_CAP) : r.len;
            end
            CMD_ENCODE: begin
                delta = r.pix - pred_prev;
                pred_prev = r.pix;
                w = code_word_tbl[delta];
                l = int'(code_len_tbl[delta]);
                for (int i = l; i > 0; i--) begin
                    pack_buf = {pack_buf[6:0], w[i-1]};
                    pack_cnt++;
                    if (pack_cnt == BYTE_BITS) begin
                        made[n] = pack_buf;
                        n++;
                        pack_buf = 8'd0;
                        pack_cnt = 0;
                    end
                end
            end
            CMD_FLUSH: begin
                // Partial byte padded with zeros at the low end
                if (pack_cnt > 0) begin
                    made[n] = pack_buf << (BYTE_BITS - pack_cnt);
                    n++;
                end
                pred_prev = 8'd0;
                pack_buf  = 8'd0;
                pack_cnt  = 0;
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++)
            expected_bytes.push_back('{data: made[k], last: (k == n - 1)});
    endtask

    // Request driver: holds a stalled request, otherwise idles in bursts or sends the next
    always @(posedge i_clk) begin : drive_requests
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_bytes('{cmd: i_command, pix: i_pixel, bits: i_code_bits,
                                len: i_code_length});
                reqs_taken++;
            end
            calm <= (pending_reqs.size() < CALM_TAIL);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap == 0 && !calm && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 18);
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req = pending_reqs.pop_front();
                    i_command     <= req.cmd;
                    i_pixel       <= req.pix;
                    i_code_bits   <= req.bits;
                    i_code_length <= req.len;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor and output stall bursts
    always @(posedge i_clk) begin : check_bytes
        t_out_byte want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", 32'(o_out_byte), 32'd0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data)
                        report_mismatch("out_byte", 32'(o_out_byte), 32'(want.data));
                    if (o_last !== want.last)
                        report_mismatch("last", 32'(o_last), 32'(want.last));
                end
                bytes_seen++;
            end
            if (recv_gap == 0 && !calm && $urandom_range(0, 9) == 0)
                recv_gap = $urandom_range(1, 18);
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles where neither channel moves anything
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles == STUCK_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
                $display("** delta_huffman_encoder: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] pix;
        int         made;
        int         row_len;
        int         pick;
        made = 0;
        gen_prev  = 8'd0;
        pred_prev = 8'd0;
        pack_buf  = 8'd0;
        pack_cnt  = 0;
        for (int s = 0; s < SYMBOLS; s++) begin
            gen_loaded[s]    = 1'b0;
            code_word_tbl[s] = 32'd0;
            code_len_tbl[s]  = 6'd0;
        end

        // Directed: zero length, single bit, saturated length, full word, byte code
        queue_request(CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
        queue_request(CMD_LOAD, 8'h01, 32'h0000_0001, 6'd1);
        queue_request(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        queue_request(CMD_LOAD, 8'h80, 32'hA5C3_0F01, 6'd32);
        queue_request(CMD_LOAD, 8'h7F, 32'h0000_005A, 6'd8);
        queue_request(CMD_LOAD, 8'h02, 32'h0000_0005, 6'd3);
        queue_request(CMD_ENCODE, 8'h00, 32'd0, 6'd0);
        queue_request(CMD_ENCODE, 8'h01, 32'd0, 6'd0);
        // Delta wraps to 0xFF: long code straddling five bytes
        queue_request(CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63);
        queue_request(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        // Nothing pending: flush sends no byte
        queue_request(CMD_FLUSH, 8'h00, 32'd0, 6'd0);
        queue_request(CMD_ENCODE, 8'h80, 32'd0, 6'd0);
        queue_request(CMD_ENCODE, 8'hFF, 32'd0, 6'd0);
        queue_request(CMD_ENCODE, 8'h7F, 32'd0, 6'd0);
        queue_request(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        queue_request(CMD_ENCODE, 8'h81, 32'd0, 6'd0);
        // Reload with bits pending; the packer must keep them
        queue_request(CMD_LOAD, 8'h02, 32'h0000_0000, 6'd5);
        queue_request(CMD_ENCODE, 8'h83, 32'd0, 6'd0);
        queue_request(CMD_ENCODE, 8'h83, 32'd0, 6'd0);
        queue_request(CMD_FLUSH, 8'h00, 32'd0, 6'd0);

        // Random: fill part of the table, then image rows, most ending in a flush
        while (loaded_syms.size() < 24) begin
            queue_random_load();
            made++;
        end
        while (made < RANDOM_ITEMS) begin
            repeat ($urandom_range(0, 3)) begin
                queue_random_load();
                made++;
            end
            row_len = $urandom_range(1, 30);
            repeat (row_len) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    queue_request(CMD_UNUSED, 8'($urandom()), $urandom(),
                                  6'($urandom_range(0, 63)));
                end else begin
                    if (pick < 8)
                        pix = 8'($urandom_range(0, 255));
                    else
                        pix = gen_prev + 8'($urandom_range(0, 4) - 2);
                    // Never encode a delta whose entry has not been loaded
                    if (!gen_loaded[8'(pix - gen_prev)])
                        pix = gen_prev +
                              8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
                    queue_request(CMD_ENCODE, pix, $urandom(), 6'($urandom_range(0, 63)));
                    made++;
                end
            end
            // Most rows close with a flush, a few run on into the next
            if ($urandom_range(0, 9) != 0) begin
                queue_request(CMD_FLUSH, 8'($urandom()), $urandom(),
                              6'($urandom_range(0, 63)));
                made++;
            end
        end
        queue_request(CMD_FLUSH, 8'd0, 32'd0, 6'd0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests taken, %0d bytes checked, %0d table entries in use",
                 reqs_taken, bytes_seen, loaded_syms.size());
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("** delta_huffman_encoder: PASSED **");
        end else begin
            $display("** delta_huffman_encoder: FAILED **");
        end
        $finish;
    end

endmodule
